FILE: rtl/sha1sh_pkg.sv
// ----------------------------------------------------------------------------
// sha1sh_pkg
// shared constants and control types for the byte-stream sha-1 hasher
// ----------------------------------------------------------------------------
package sha1sh_pkg;

    localparam int WORD_W   = 32;
    localparam int BLOCK_W  = 512;
    localparam int LEN_W    = 64;
    localparam int FILL_W   = 6;
    localparam int ROUND_W  = 7;
    localparam int WIDX_W   = 3;
    localparam int OUT_DW   = 40;

    localparam logic [WORD_W-1:0] IV0 = 32'h67452301;
    localparam logic [WORD_W-1:0] IV1 = 32'hefcdab89;
    localparam logic [WORD_W-1:0] IV2 = 32'h98badcfe;
    localparam logic [WORD_W-1:0] IV3 = 32'h10325476;
    localparam logic [WORD_W-1:0] IV4 = 32'hc3d2e1f0;

    localparam logic [WORD_W-1:0] K0 = 32'h5a827999;
    localparam logic [WORD_W-1:0] K1 = 32'h6ed9eba1;
    localparam logic [WORD_W-1:0] K2 = 32'h8f1bbcdc;
    localparam logic [WORD_W-1:0] K3 = 32'hca62c1d6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // byte source for a buffer append
    localparam logic [1:0] SRC_DATA = 2'd0;
    localparam logic [1:0] SRC_PAD  = 2'd1;
    localparam logic [1:0] SRC_ZERO = 2'd2;
    localparam logic [1:0] SRC_LEN  = 2'd3;

    // round group, selects f and k
    localparam logic [1:0] PH_CH  = 2'd0;
    localparam logic [1:0] PH_P1  = 2'd1;
    localparam logic [1:0] PH_MAJ = 2'd2;
    localparam logic [1:0] PH_P2  = 2'd3;

    localparam logic [WIDX_W-1:0] LAST_WIDX = 3'd4;
    localparam logic [FILL_W-1:0] LEN_POS   = 6'd56;
    localparam logic [FILL_W-1:0] FULL_POS  = 6'd63;
    localparam logic [ROUND_W-1:0] LAST_RND = 7'd79;

    typedef struct packed {
        logic              append;
        logic [1:0]        byte_src;
        logic [2:0]        len_sel;
        logic              len_inc;
        logic              load;
        logic              round;
        logic [1:0]        phase;
        logic              add;
        logic              emit;
        logic [WIDX_W-1:0] widx;
        logic              init;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

FILE: rtl/sha1_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// sha1_stream_hasher_top
// byte-stream sha-1 hasher with a 160-bit digest read out as five words
//
// input channel: one transfer per byte; tuser[0] = 0 appends tdata[7:0] to
// the message, tuser[0] = 1 finishes the message (tdata ignored).
// output channel: after a finish, five transfers carry h0..h4, tdata holds
// the word and its index, tlast marks h4. the hasher then starts a new
// empty message.
// data bytes are taken one per cycle while the hasher is idle; every 64th
// byte starts a compression that holds off input (load, 80 rounds of one
// shared round unit, chaining add). a finish appends padding/length bytes
// up to the end of the block (plus a second block when fewer than 9 bytes
// are free), compresses each block, then emits the words and restarts.
// after reset the chaining words hold the initial values and the message
// is empty. a stalled output only holds the readout; bytes of the next
// message are taken while the last word waits.
// ----------------------------------------------------------------------------
module sha1_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic [0:0]  s_axis_tuser,   // kind[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // digest_word[31:0], word_index[34:32], zero[39:35]
    output logic        m_axis_tlast    // last_word
);
    import sha1sh_pkg::*;

    t_ctrl_cmd         cmd;
    t_dp_status        sts;
    logic              in_ready;
    logic [WORD_W-1:0] digest_word;
    logic [WIDX_W-1:0] word_index;

    sha1sh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_kind     (s_axis_tuser[0]),
        .o_in_ready (in_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    sha1sh_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (s_axis_tdata),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_digest_word (digest_word),
        .o_word_index  (word_index),
        .o_last_word   (m_axis_tlast)
    );

    assign s_axis_tready = in_ready;
    assign m_axis_tdata  = {5'b00000, word_index, digest_word};

endmodule

FILE: rtl/sha1sh_dp.sv
// ----------------------------------------------------------------------------
// sha1sh_dp
// block buffer with in-place message schedule, round logic, chaining
// words, bit length and the result register
// ----------------------------------------------------------------------------
module sha1sh_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [7:0]            i_data_byte,
    input  sha1sh_pkg::t_ctrl_cmd i_cmd,
    output sha1sh_pkg::t_dp_status o_sts,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [31:0]           o_digest_word,
    output logic [2:0]            o_word_index,
    output logic                  o_last_word
);
    import sha1sh_pkg::*;

    // block window, word t of the schedule sits in the top 32 bits
    logic [BLOCK_W-1:0]  r_blk;
    logic [WORD_W-1:0]   r_h [5];
    logic [WORD_W-1:0]   r_a, r_b, r_c, r_d, r_e;
    logic [LEN_W-1:0]    r_len;
    logic                r_ovalid;
    logic [WORD_W-1:0]   r_oword;
    logic [WIDX_W-1:0]   r_oidx;
    logic                r_olast;

    logic [7:0]          byte_in;
    logic [7:0]          len_byte;
    logic [WORD_W-1:0]   w_t, w_x, w_new, f_val, k_val, t_sum;

    assign len_byte = 8'(r_len >> {~i_cmd.len_sel, 3'b000});

    always_comb begin
        case (i_cmd.byte_src)
            SRC_DATA: byte_in = i_data_byte;
            SRC_PAD:  byte_in = PAD_BYTE;
            SRC_ZERO: byte_in = 8'h00;
            SRC_LEN:  byte_in = len_byte;
            default:  byte_in = 8'h00;
        endcase
    end

    assign w_t   = r_blk[BLOCK_W-1 -: WORD_W];
    assign w_x   = r_blk[BLOCK_W-1-2*WORD_W -: WORD_W] ^ r_blk[BLOCK_W-1-8*WORD_W -: WORD_W]
                 ^ r_blk[BLOCK_W-1-13*WORD_W -: WORD_W] ^ w_t;
    assign w_new = {w_x[30:0], w_x[31]};

    always_comb begin
        case (i_cmd.phase)
            PH_CH: begin
                f_val = (r_b & r_c) | (~r_b & r_d);
                k_val = K0;
            end
            PH_P1: begin
                f_val = r_b ^ r_c ^ r_d;
                k_val = K1;
            end
            PH_MAJ: begin
                f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
                k_val = K2;
            end
            PH_P2: begin
                f_val = r_b ^ r_c ^ r_d;
                k_val = K3;
            end
            default: begin
                f_val = r_b ^ r_c ^ r_d;
                k_val = K3;
            end
        endcase
    end

    assign t_sum = {r_a[26:0], r_a[31:27]} + f_val + r_e + w_t + k_val;

    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_blk <= {r_blk[BLOCK_W-9:0], byte_in};
        end else if (i_cmd.round) begin
            r_blk <= {r_blk[BLOCK_W-WORD_W-1:0], w_new};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_cmd.round) begin
            r_a <= t_sum;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.init) begin
            r_h[0] <= IV0;
            r_h[1] <= IV1;
            r_h[2] <= IV2;
            r_h[3] <= IV3;
            r_h[4] <= IV4;
            r_len  <= '0;
        end else begin
            if (i_cmd.add) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end
            if (i_cmd.len_inc) begin
                r_len <= r_len + LEN_W'(8);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_oword <= r_h[i_cmd.widx];
            r_oidx  <= i_cmd.widx;
            r_olast <= (i_cmd.widx == LAST_WIDX);
        end
    end

    assign o_sts.out_free = !r_ovalid || i_out_ready;
    assign o_out_valid    = r_ovalid;
    assign o_digest_word  = r_oword;
    assign o_word_index   = r_oidx;
    assign o_last_word    = r_olast;

endmodule

FILE: rtl/sha1sh_ctrl.sv
// ----------------------------------------------------------------------------
// sha1sh_ctrl
// sequencer: byte fill count, padding, round counter and digest readout
// ----------------------------------------------------------------------------
module sha1sh_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_kind,
    output logic                   o_in_ready,
    output sha1sh_pkg::t_ctrl_cmd  o_cmd,
    input  sha1sh_pkg::t_dp_status i_sts
);
    import sha1sh_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_ADD   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;
    localparam logic [2:0] ST_INIT  = 3'd6;

    logic [2:0]         r_state, n_state;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [ROUND_W-1:0] r_rnd, n_rnd;
    logic [WIDX_W-1:0]  r_widx, n_widx;
    logic               r_fin, n_fin;
    logic               r_lenph, n_lenph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_rnd   <= '0;
            r_widx  <= '0;
            r_fin   <= 1'b0;
            r_lenph <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_rnd   <= n_rnd;
            r_widx  <= n_widx;
            r_fin   <= n_fin;
            r_lenph <= n_lenph;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_rnd   = r_rnd;
        n_widx  = r_widx;
        n_fin   = r_fin;
        n_lenph = r_lenph;
        o_cmd   = '0;
        o_cmd.len_sel = r_fill[2:0];
        o_cmd.widx    = r_widx;
        if (r_rnd < 7'd20) begin
            o_cmd.phase = PH_CH;
        end else if (r_rnd < 7'd40) begin
            o_cmd.phase = PH_P1;
        end else if (r_rnd < 7'd60) begin
            o_cmd.phase = PH_MAJ;
        end else begin
            o_cmd.phase = PH_P2;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.append = 1'b1;
                    n_fill = r_fill + 1'b1;
                    if (!i_kind) begin
                        o_cmd.byte_src = SRC_DATA;
                        o_cmd.len_inc  = 1'b1;
                        if (r_fill == FULL_POS) begin
                            n_state = ST_LOAD;
                        end
                    end else begin
                        o_cmd.byte_src = SRC_PAD;
                        n_fin   = 1'b1;
                        n_lenph = (r_fill < LEN_POS);
                        n_state = (r_fill == FULL_POS) ? ST_LOAD : ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                o_cmd.append = 1'b1;
                if (r_fill >= LEN_POS && r_lenph) begin
                    o_cmd.byte_src = SRC_LEN;
                end else begin
                    o_cmd.byte_src = SRC_ZERO;
                end
                n_fill = r_fill + 1'b1;
                if (r_fill == FULL_POS) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_rnd   = '0;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_rnd = r_rnd + 1'b1;
                if (r_rnd == LAST_RND) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                o_cmd.add = 1'b1;
                n_rnd = '0;
                if (!r_fin) begin
                    n_state = ST_IDLE;
                end else if (r_lenph) begin
                    n_widx  = '0;
                    n_state = ST_OUT;
                end else begin
                    n_lenph = 1'b1;
                    n_state = ST_PAD;
                end
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_widx = r_widx + 1'b1;
                    if (r_widx == LAST_WIDX) begin
                        n_state = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                o_cmd.init = 1'b1;
                n_fill  = '0;
                n_widx  = '0;
                n_fin   = 1'b0;
                n_lenph = 1'b0;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_rnd == LAST_RND) |=> (r_state == ST_ADD))
        else $error("compression did not end after the last round");

    a_load_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> (r_fill == '0))
        else $error("compression started on a partial block");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("digest word written over a pending transfer");

    a_out_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> (r_fin && r_lenph))
        else $error("digest readout without a length block");

endmodule

FILE: tb/sv/sha1sh_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha1sh_tb_pkg
// item kinds and digest framing shared by the hasher bench and its checker
// ----------------------------------------------------------------------------
package sha1sh_tb_pkg;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam int DIGEST_WORDS = 5;

endpackage

FILE: tb/sv/sha1_digest_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha1_digest_checker
// watches both stream channels of the sha-1 hasher, runs its own sha-1 on
// every accepted byte and finish, and compares each digest word transfer
// with the oldest predicted word
// ----------------------------------------------------------------------------
module sha1_digest_checker
    import sha1sh_pkg::*;
    import sha1sh_tb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // data_byte[7:0]
    input  logic [0:0]  i_s_tuser,   // kind[0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,   // digest_word[31:0], word_index[34:32], zero[39:35]
    input  logic        i_m_tlast,   // last_word
    output int          o_error_count,
    output int          o_pending_count
);

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [WIDX_W-1:0] index;
        logic              last;
    } t_digest_xfer;

    t_digest_xfer      digest_words_q[$];
    logic [WORD_W-1:0] chain[DIGEST_WORDS];
    logic [7:0]        msg_block[64];
    int unsigned       block_fill;
    logic [LEN_W-1:0]  msg_bits;

    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void sha1_restart();
        chain[0]   = IV0;
        chain[1]   = IV1;
        chain[2]   = IV2;
        chain[3]   = IV3;
        chain[4]   = IV4;
        block_fill = 0;
        msg_bits   = '0;
    endfunction

    function automatic void sha1_compress_block();
        logic [WORD_W-1:0] sched[16];
        logic [WORD_W-1:0] a, b, c, d, e, f, k, wt, t;
        int r;
        for (r = 0; r < 16; r++) begin
            sched[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
        end
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (r = 0; r < 80; r++) begin
            if (r < 16) begin
                wt = sched[r];
            end else begin
                wt = rotl32(sched[(r-3)%16] ^ sched[(r-8)%16] ^ sched[(r-14)%16] ^ sched[r%16], 1);
                sched[r%16] = wt;
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = K0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end else begin
                f = b ^ c ^ d;
                k = K3;
            end
            t = rotl32(a, 5) + f + e + wt + k;
            e = d;
            d = c;
            c = rotl32(b, 30);
            b = a;
            a = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endfunction

    function automatic void sha1_put_byte(input logic [7:0] b);
        msg_block[block_fill] = b;
        block_fill++;
        if (block_fill == 64) begin
            sha1_compress_block();
            block_fill = 0;
        end
    endfunction

    function automatic void sha1_finish();
        t_digest_xfer x;
        int i;
        sha1_put_byte(PAD_BYTE);
        while (block_fill != LEN_POS) sha1_put_byte(8'h00);
        for (i = 0; i < 8; i++) sha1_put_byte(msg_bits[63-8*i -: 8]);
        for (i = 0; i < DIGEST_WORDS; i++) begin
            x.word  = chain[i];
            x.index = WIDX_W'(i);
            x.last  = (x.index == LAST_WIDX);
            digest_words_q.push_back(x);
        end
        sha1_restart();
    endfunction

    always @(posedge i_clk) begin
        t_digest_xfer got, want;
        if (!i_rst_n) begin
            sha1_restart();
            digest_words_q.delete();
            o_error_count = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.word  = i_m_tdata[31:0];
                got.index = i_m_tdata[34:32];
                got.last  = i_m_tlast;
                if (digest_words_q.size() == 0) begin
                    o_error_count++;
                    $display("%0t ns: digest transfer with nothing pending, expected none, actual word=%h index=%0d last=%b",
                             $time, got.word, got.index, got.last);
                end else begin
                    want = digest_words_q.pop_front();
                    if (got !== want) begin
                        o_error_count++;
                        $display("%0t ns: digest mismatch, expected word=%h index=%0d last=%b, actual word=%h index=%0d last=%b",
                                 $time, want.word, want.index, want.last,
                                 got.word, got.index, got.last);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0] == KIND_FINISH) begin
                    sha1_finish();
                end else begin
                    sha1_put_byte(i_s_tdata);
                    msg_bits += 64'd8;
                end
            end
        end
        o_pending_count = digest_words_q.size();
    end

endmodule

FILE: tb/sv/sha1_stream_hasher_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha1_stream_hasher_top_tb
// drives byte messages and finishes into the sha-1 hasher: known vectors,
// a long output hold, then random messages with padding-corner lengths
// under changing back-pressure; the checker predicts and compares digests
// ----------------------------------------------------------------------------
module sha1_stream_hasher_top_tb;
    import sha1sh_tb_pkg::*;

    localparam int  HALF_PERIOD  = 6;
    localparam int  RESET_CYCLES = 9;
    localparam int  TOTAL_ITEMS  = 310;
    localparam int  HOLD_CYCLES  = 500;
    localparam int  DRAIN_CYCLES = 250;
    localparam time TIMEOUT_NS   = 5_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    int   error_count;
    int   pending_words;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   items_sent;
    logic hold_req;

    int boundary_lens[8] = '{55, 56, 57, 63, 64, 65, 119, 120};

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    sha1_stream_hasher_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    sha1_digest_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_axis_tvalid),
        .i_s_tready      (s_axis_tready),
        .i_s_tdata       (s_axis_tdata),
        .i_s_tuser       (s_axis_tuser),
        .i_m_tvalid      (m_axis_tvalid),
        .i_m_tready      (m_axis_tready),
        .i_m_tdata       (m_axis_tdata),
        .i_m_tlast       (m_axis_tlast),
        .o_error_count   (error_count),
        .o_pending_count (pending_words)
    );

    task automatic send_item(input logic kind, input logic [7:0] data);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic send_message(input int len);
        int i;
        for (i = 0; i < len; i++) send_item(KIND_DATA, 8'($urandom_range(255)));
        send_item(KIND_FINISH, 8'($urandom_range(255)));
    endtask

    task automatic wait_digests_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
    endtask

    // output side: random tready, or a long hold on request
    initial begin
        int hold_n;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                for (hold_n = 0; hold_n < HOLD_CYCLES; hold_n++) begin
                    m_axis_tready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial begin
        int len;
        hold_req      = 1'b0;
        items_sent    = 0;
        src_idle_pct  = 24;
        snk_idle_pct  = 85;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tuser  <= KIND_DATA;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty message, finish carries a nonzero byte that must be ignored
        send_item(KIND_FINISH, 8'hff);
        send_item(KIND_DATA, "a");
        send_item(KIND_DATA, "b");
        send_item(KIND_DATA, "c");
        send_item(KIND_FINISH, 8'h00);
        send_item(KIND_DATA, 8'h00);
        send_item(KIND_DATA, 8'hff);
        send_item(KIND_FINISH, 8'h5a);
        wait_digests_drained();

        // output held off while input keeps coming, so the hasher backs up
        src_idle_pct = 0;
        hold_req     = 1'b1;
        send_message(24);
        send_message(24);
        send_message(16);
        src_idle_pct = 24;

        while (items_sent < TOTAL_ITEMS) begin
            if (items_sent >= 2 * TOTAL_ITEMS / 3) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else if (items_sent >= TOTAL_ITEMS / 3) begin
                src_idle_pct = 85;
                snk_idle_pct = 24;
            end
            case ($urandom_range(3))
                0, 1: len = $urandom_range(8);
                2:    len = boundary_lens[$urandom_range(7)];
                default: len = $urandom_range(130);
            endcase
            if (len > TOTAL_ITEMS - items_sent - 1) len = TOTAL_ITEMS - items_sent - 1;
            send_message(len);
        end

        wait_digests_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[sha1_stream_hasher_top] OK");
        end else begin
            $display("[sha1_stream_hasher_top] ERROR");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("[sha1_stream_hasher_top] ERROR");
        $finish;
    end

endmodule

FILE: sha1_stream_hasher_top.f
rtl/sha1sh_pkg.sv
rtl/sha1sh_dp.sv
rtl/sha1sh_ctrl.sv
rtl/sha1_stream_hasher_top.sv
tb/sv/sha1sh_tb_pkg.sv
tb/sv/sha1_digest_checker.sv
tb/sv/sha1_stream_hasher_top_tb.sv
